// ===== sv/sorted_min_priority_queue_macros.svh =====
// Assertion macros for the priority queue RTL
`ifndef SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next clock edge
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// Types and constants shared by the sorted priority queue modules
`default_nettype none

package spq_pkg;

    // Default number of cells in the chain
    localparam int QUEUE_DEPTH_DEF = 16;

    // Width of the occupancy field in a result beat
    localparam int OCC_W = 5;

    // Width of key and payload
    localparam int DATA_W = 32;

    // Operation carried in s_tuser
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] payload;
    } entry_t;

    // Per-beat commands broadcast to every cell
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/sorted_min_priority_queue.sv =====
// Bounded min-priority queue: usage
// Input channel s_*: one beat is one operation. s_tuser selects push (0) or
//   pop (1); s_tdata carries the key (bits 31:0) and payload (bits 63:32) of
//   a push and is ignored on a pop.
// Result channel m_*: exactly one beat per input beat, in order, giving the
//   head entry, head valid flag, occupancy and overflow flag after the
//   operation. An empty queue reports head key and payload as zero.
// The entries sit in a chain of QUEUE_DEPTH cells, head in cell 0. Every
//   cell compares its key with the pushed key in parallel and shifts or holds
//   in the same cycle, so one operation completes per clock while m_tready is high.
// The result beat is valid in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while m_tready is high.
// A push into a full queue is dropped and reported with overflow set; a pop
//   of an empty queue leaves the queue as it is.
// Stall: the result register holds its beat while m_tready is low, and
//   s_tready drops until that beat is taken.
// Reset (aresetn low, synchronous): the queue empties and no result is
//   pending; the queue takes input in the first cycle after reset.
`default_nettype none
`include "sorted_min_priority_queue_macros.svh"

module sorted_min_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,  // [31:0] key, [63:32] payload
    input  wire  [0:0]  s_tuser,  // [0] operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,  // [31:0] head_key, [63:32] head_payload,
                                  // [68:64] occupancy, [71:69] zero
    output logic [1:0]  m_tuser   // [0] head_valid, [1] overflow
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                 in_beat;
    spq_pkg::op_t         op;
    spq_pkg::entry_t      new_entry;
    spq_pkg::cell_ctrl_t  ctrl;
    logic                 full;
    logic                 empty;
    logic                 drop;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 ins       [QUEUE_DEPTH];
    spq_pkg::entry_t      cell_q    [QUEUE_DEPTH];
    spq_pkg::entry_t      cell_d    [QUEUE_DEPTH];

    logic                 m_tvalid_reg;
    logic                 head_valid_reg;
    logic                 overflow_reg;
    logic signed [31:0]   head_key_reg;
    logic signed [31:0]   head_payload_reg;
    logic [spq_pkg::OCC_W-1:0] occ_reg;

    // Accept while the result register is free or being drained
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign op        = spq_pkg::op_t'(s_tuser[0]);
    assign new_entry = '{key: s_tdata[31:0], payload: s_tdata[63:32]};

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign drop  = in_beat && (op == spq_pkg::OP_PUSH) && full;

    assign ctrl.push_en = in_beat && (op == spq_pkg::OP_PUSH) && !full;
    assign ctrl.pop_en  = in_beat && (op == spq_pkg::OP_POP) && !empty;

    // Track the fill level
    always_comb begin
        count_next = count_reg;
        if (ctrl.push_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Chain of cells, head first
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic            prev_ins_w;
        spq_pkg::entry_t prev_w;
        spq_pkg::entry_t succ_w;

        if (i == 0) begin : g_first
            assign prev_ins_w = 1'b0;
            assign prev_w     = new_entry;
        end else begin : g_mid
            assign prev_ins_w = ins[i-1];
            assign prev_w     = cell_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign succ_w = '0;
        end else begin : g_inner
            assign succ_w = cell_q[i+1];
        end

        spq_cell #(
            .IS_HEAD (i == 0)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_valid (CNT_W'(i) < count_reg),
            .new_entry  (new_entry),
            .prev_ins   (prev_ins_w),
            .prev_entry (prev_w),
            .succ_entry (succ_w),
            .ins        (ins[i]),
            .entry_out  (cell_q[i]),
            .entry_next (cell_d[i])
        );
    end

    // Capture the result of each accepted beat, hold it while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_beat) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            head_valid_reg   <= (count_next != '0);
            head_key_reg     <= (count_next != '0) ? cell_d[0].key : '0;
            head_payload_reg <= (count_next != '0) ? cell_d[0].payload : '0;
            occ_reg          <= spq_pkg::OCC_W'(count_next);
            overflow_reg     <= drop;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, occ_reg, head_payload_reg, head_key_reg};
    assign m_tuser  = {overflow_reg, head_valid_reg};

    // Fill level never passes the chain length
    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "count exceeds depth")
    // The two front cells stay in key order
    `SPQ_ASSERT(a_front_sorted, (count_reg < CNT_W'(2)) || (cell_q[0].key <= cell_q[1].key), "front cells out of order")
    // A dropped push only happens on a full queue and leaves it full
    `SPQ_ASSERT_NEXT(a_drop_full, drop, count_reg == CNT_W'(QUEUE_DEPTH) && m_tuser[1], "overflow without full queue")
    // Every accepted beat yields a pending result next cycle
    `SPQ_ASSERT_NEXT(a_result_pending, in_beat, m_tvalid, "accepted beat produced no result")
    // A pending result keeps the head-valid flag consistent with occupancy
    `SPQ_ASSERT(a_head_flag, !m_tvalid || (m_tuser[0] == (m_tdata[68:64] != 5'd0)) || (QUEUE_DEPTH > 31), "head flag disagrees with occupancy")

endmodule

`default_nettype wire

// ===== sv/spq_cell.sv =====
// One compare-and-shift cell of the sorted queue chain
`default_nettype none

module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  wire                      aclk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire                      cell_valid,
    input  wire spq_pkg::entry_t     new_entry,
    input  wire                      prev_ins,
    input  wire spq_pkg::entry_t     prev_entry,
    input  wire spq_pkg::entry_t     succ_entry,
    output logic                     ins,
    output spq_pkg::entry_t          entry_out,
    output spq_pkg::entry_t          entry_next
);

    spq_pkg::entry_t entry_reg;

    // Decide whether the new key lands at or before this cell; the head keeps
    // its place against an equal key, other cells yield to it
    always_comb begin
        if (!cell_valid) begin
            ins = 1'b1;
        end else if (IS_HEAD) begin
            ins = (new_entry.key < entry_reg.key);
        end else begin
            ins = !(entry_reg.key < new_entry.key);
        end
    end

    // Shift right on insert, shift left on pop, otherwise hold
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.push_en && ins) begin
            entry_next = prev_ins ? prev_entry : new_entry;
        end else if (ctrl.pop_en) begin
            entry_next = succ_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule

`default_nettype wire
